>>> hw/rtl/stlr_pkg.sv
// Package for the slot table with live and retired lists.
// Holds sizes, command and status codes, sequencer states and the structs
// shared by the top level and the link memory. No dependencies.
package stlr_pkg;

    localparam int ENTRIES = 128;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int LINK_W  = IDX_W + 1;
    localparam int KEY_W   = 64;
    localparam int CNT_W   = 8;

    // Link value meaning "no slot": the top bit set.
    localparam logic [LINK_W-1:0] NONE_LINK = LINK_W'(ENTRIES);

    typedef enum logic [1:0] {
        CMD_PROBE  = 2'd0,
        CMD_ATTACH = 2'd1,
        CMD_MARK   = 2'd2,
        CMD_REAP   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_REATTACHED  = 3'd0,
        ST_ADDED       = 3'd1,
        ST_FULL        = 3'd2,
        ST_UNSUPPORTED = 3'd3,
        ST_DONE        = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_READ,
        S_EVAL,
        S_UNLINK,
        S_LINK1,
        S_LINK2,
        S_FINISH
    } t_state;

    typedef struct packed {
        t_cmd              command;
        logic [KEY_W-1:0]  identity_key;
        logic [KEY_W-1:0]  path_key;
        logic              is_block_device;
        logic [IDX_W-1:0]  slot_index;
    } t_item;

    typedef struct packed {
        t_status           status;
        logic [IDX_W-1:0]  slot;
        logic              found_live;
        logic [CNT_W-1:0]  moved_count;
    } t_result;

    // One write port for each link array.
    typedef struct packed {
        logic              we_next;
        logic [IDX_W-1:0]  wa_next;
        logic [LINK_W-1:0] wd_next;
        logic              we_prev;
        logic [IDX_W-1:0]  wa_prev;
        logic [LINK_W-1:0] wd_prev;
    } t_link_wr;

    typedef struct packed {
        logic [LINK_W-1:0] next;
        logic [LINK_W-1:0] prev;
    } t_link_rd;

endpackage

>>> hw/rtl/slot_table_with_live_and_retired_lists_unit.sv
// Top level of the slot table with live and retired lists.
// Depends on stlr_pkg and stlr_link_mem.

// A command is taken when start is high and busy is low; busy then stays
// high until its single result has been shown. The result is on o_result
// for exactly one cycle, marked by o_result_valid, and the receiver cannot
// stall it, so it must take every transfer. Commands walk the linked lists
// one slot at a time through the registered link and key memories: each
// visited slot passes through a read state and an evaluate state. Moving a
// slot between lists goes through unlink, link and tail patch states, and
// each command passes a start state and a result state. A probe or reap
// walks the live list and a reap moves the slots marked died; an attach
// walks the retired list the same way, and may recycle the retired head.
// Marking a slot goes from the start state straight to the result state.
// Both lists keep tail registers, so appending never walks a list.
module slot_table_with_live_and_retired_lists_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  stlr_pkg::t_item   i_item,
    output logic              o_result_valid,
    output stlr_pkg::t_result o_result
);

    stlr_pkg::t_state r_state, n_state;
    stlr_pkg::t_item  r_in, n_in;

    logic [stlr_pkg::LINK_W-1:0] r_cur, n_cur;
    logic [stlr_pkg::LINK_W-1:0] r_nxt, n_nxt;
    logic [stlr_pkg::LINK_W-1:0] r_old_tail, n_old_tail;
    logic [stlr_pkg::LINK_W-1:0] r_live_head, n_live_head;
    logic [stlr_pkg::LINK_W-1:0] r_live_tail, n_live_tail;
    logic [stlr_pkg::LINK_W-1:0] r_ret_head, n_ret_head;
    logic [stlr_pkg::LINK_W-1:0] r_ret_tail, n_ret_tail;
    logic [stlr_pkg::LINK_W-1:0] r_never_used, n_never_used;
    logic                        r_recycle, n_recycle;

    stlr_pkg::t_status           r_status, n_status;
    logic [stlr_pkg::IDX_W-1:0]  r_slot, n_slot;
    logic                        r_found, n_found;
    logic [stlr_pkg::CNT_W-1:0]  r_moved, n_moved;

    logic [stlr_pkg::ENTRIES-1:0] r_died;
    logic                         r_rd_died;
    logic                         died_set;
    logic                         died_clr;

    // Key memories; read every cycle at the current slot.
    logic [stlr_pkg::KEY_W-1:0] mem_ident [stlr_pkg::ENTRIES];
    logic [stlr_pkg::KEY_W-1:0] mem_path  [stlr_pkg::ENTRIES];
    logic [stlr_pkg::KEY_W-1:0] r_rd_ident;
    logic [stlr_pkg::KEY_W-1:0] r_rd_path;
    logic                       key_we;

    stlr_pkg::t_link_wr link_wr;
    stlr_pkg::t_link_rd link_rd;

    logic [stlr_pkg::IDX_W-1:0]  cur_idx;
    logic                        walk_go;
    logic [stlr_pkg::LINK_W-1:0] walk_to;
    logic                        is_reap;

    assign cur_idx = r_cur[stlr_pkg::IDX_W-1:0];
    assign is_reap = (r_in.command == stlr_pkg::CMD_REAP);

    stlr_link_mem u_link_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (link_wr),
        .i_rd_addr (cur_idx),
        .o_rd      (link_rd)
    );

    always_ff @(posedge i_clk) begin
        if (key_we) begin
            mem_ident[cur_idx] <= r_in.identity_key;
            mem_path[cur_idx]  <= r_in.path_key;
        end
        r_rd_ident <= mem_ident[cur_idx];
        r_rd_path  <= mem_path[cur_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_died <= '0;
        end else if (died_set) begin
            r_died[r_in.slot_index] <= 1'b1;
        end else if (died_clr) begin
            r_died[cur_idx] <= 1'b0;
        end
    end

    // The died flag of the current slot is read with the keys and links.
    always_ff @(posedge i_clk) begin
        r_rd_died <= r_died[cur_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= stlr_pkg::S_IDLE;
            r_live_head  <= stlr_pkg::NONE_LINK;
            r_live_tail  <= stlr_pkg::NONE_LINK;
            r_ret_head   <= stlr_pkg::NONE_LINK;
            r_ret_tail   <= stlr_pkg::NONE_LINK;
            r_never_used <= '0;
            r_recycle    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_live_head  <= n_live_head;
            r_live_tail  <= n_live_tail;
            r_ret_head   <= n_ret_head;
            r_ret_tail   <= n_ret_tail;
            r_never_used <= n_never_used;
            r_recycle    <= n_recycle;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in       <= n_in;
        r_cur      <= n_cur;
        r_nxt      <= n_nxt;
        r_old_tail <= n_old_tail;
        r_status   <= n_status;
        r_slot     <= n_slot;
        r_found    <= n_found;
        r_moved    <= n_moved;
    end

    always_comb begin
        n_state      = r_state;
        n_in         = r_in;
        n_cur        = r_cur;
        n_nxt        = r_nxt;
        n_old_tail   = r_old_tail;
        n_live_head  = r_live_head;
        n_live_tail  = r_live_tail;
        n_ret_head   = r_ret_head;
        n_ret_tail   = r_ret_tail;
        n_never_used = r_never_used;
        n_recycle    = r_recycle;
        n_status     = r_status;
        n_slot       = r_slot;
        n_found      = r_found;
        n_moved      = r_moved;
        died_set     = 1'b0;
        died_clr     = 1'b0;
        key_we       = 1'b0;
        link_wr      = '0;
        walk_go      = 1'b0;
        walk_to      = stlr_pkg::NONE_LINK;

        unique case (r_state)
            stlr_pkg::S_IDLE: begin
                if (start) begin
                    n_in      = i_item;
                    n_status  = stlr_pkg::ST_DONE;
                    n_slot    = '0;
                    n_found   = 1'b0;
                    n_moved   = '0;
                    n_recycle = 1'b0;
                    n_state   = stlr_pkg::S_START;
                end
            end
            stlr_pkg::S_START: begin
                unique case (r_in.command)
                    stlr_pkg::CMD_PROBE: begin
                        walk_go = 1'b1;
                        walk_to = r_live_head;
                    end
                    stlr_pkg::CMD_ATTACH: begin
                        if (!r_in.is_block_device) begin
                            n_status = stlr_pkg::ST_UNSUPPORTED;
                            n_state  = stlr_pkg::S_FINISH;
                        end else begin
                            walk_go = 1'b1;
                            walk_to = r_ret_head;
                        end
                    end
                    stlr_pkg::CMD_MARK: begin
                        died_set = 1'b1;
                        n_state  = stlr_pkg::S_FINISH;
                    end
                    stlr_pkg::CMD_REAP: begin
                        walk_go = 1'b1;
                        walk_to = r_live_head;
                    end
                endcase
            end
            stlr_pkg::S_READ: begin
                n_state = stlr_pkg::S_EVAL;
            end
            stlr_pkg::S_EVAL: begin
                unique case (r_in.command)
                    stlr_pkg::CMD_PROBE: begin
                        if (r_rd_path == r_in.path_key) begin
                            n_found = 1'b1;
                            n_state = stlr_pkg::S_FINISH;
                        end else begin
                            walk_go = 1'b1;
                            walk_to = link_rd.next;
                        end
                    end
                    stlr_pkg::CMD_ATTACH: begin
                        if (r_recycle) begin
                            n_status = stlr_pkg::ST_ADDED;
                            n_slot   = cur_idx;
                            n_state  = stlr_pkg::S_UNLINK;
                        end else if (r_rd_ident == r_in.identity_key) begin
                            n_status = stlr_pkg::ST_REATTACHED;
                            n_slot   = cur_idx;
                            n_state  = stlr_pkg::S_UNLINK;
                        end else begin
                            walk_go = 1'b1;
                            walk_to = link_rd.next;
                        end
                    end
                    stlr_pkg::CMD_REAP: begin
                        n_nxt = link_rd.next;
                        if (r_rd_died) begin
                            died_clr = 1'b1;
                            n_moved  = r_moved + 1'b1;
                            n_state  = stlr_pkg::S_UNLINK;
                        end else begin
                            walk_go = 1'b1;
                            walk_to = link_rd.next;
                        end
                    end
                    stlr_pkg::CMD_MARK: begin
                        n_state = stlr_pkg::S_FINISH;
                    end
                endcase
            end
            stlr_pkg::S_UNLINK: begin
                // Bridge the neighbors of the current slot on its old list.
                if (!link_rd.prev[stlr_pkg::IDX_W]) begin
                    link_wr.we_next = 1'b1;
                    link_wr.wa_next = link_rd.prev[stlr_pkg::IDX_W-1:0];
                    link_wr.wd_next = link_rd.next;
                end else if (is_reap) begin
                    n_live_head = link_rd.next;
                end else begin
                    n_ret_head = link_rd.next;
                end
                if (!link_rd.next[stlr_pkg::IDX_W]) begin
                    link_wr.we_prev = 1'b1;
                    link_wr.wa_prev = link_rd.next[stlr_pkg::IDX_W-1:0];
                    link_wr.wd_prev = link_rd.prev;
                end else if (is_reap) begin
                    n_live_tail = link_rd.prev;
                end else begin
                    n_ret_tail = link_rd.prev;
                end
                n_state = stlr_pkg::S_LINK1;
            end
            stlr_pkg::S_LINK1: begin
                // Append the current slot at the tail of its new list.
                link_wr.we_next = 1'b1;
                link_wr.wa_next = cur_idx;
                link_wr.wd_next = stlr_pkg::NONE_LINK;
                link_wr.we_prev = 1'b1;
                link_wr.wa_prev = cur_idx;
                key_we          = (r_in.command == stlr_pkg::CMD_ATTACH);
                if (is_reap) begin
                    link_wr.wd_prev = r_ret_tail;
                    n_old_tail      = r_ret_tail;
                    n_ret_tail      = r_cur;
                    if (r_ret_tail[stlr_pkg::IDX_W]) begin
                        n_ret_head = r_cur;
                    end
                end else begin
                    link_wr.wd_prev = r_live_tail;
                    n_old_tail      = r_live_tail;
                    n_live_tail     = r_cur;
                    if (r_live_tail[stlr_pkg::IDX_W]) begin
                        n_live_head = r_cur;
                    end
                end
                n_state = stlr_pkg::S_LINK2;
            end
            stlr_pkg::S_LINK2: begin
                if (!r_old_tail[stlr_pkg::IDX_W]) begin
                    link_wr.we_next = 1'b1;
                    link_wr.wa_next = r_old_tail[stlr_pkg::IDX_W-1:0];
                    link_wr.wd_next = r_cur;
                end
                if (is_reap) begin
                    walk_go = 1'b1;
                    walk_to = r_nxt;
                end else begin
                    n_state = stlr_pkg::S_FINISH;
                end
            end
            stlr_pkg::S_FINISH: begin
                n_state = stlr_pkg::S_IDLE;
            end
            default: begin
                n_state = stlr_pkg::S_IDLE;
            end
        endcase

        // Step of a list walk: visit the next slot, or end the walk. An
        // attach that found no retired match allocates a slot here, or reports full.
        if (walk_go) begin
            if (!walk_to[stlr_pkg::IDX_W]) begin
                n_cur   = walk_to;
                n_state = stlr_pkg::S_READ;
            end else if (r_in.command == stlr_pkg::CMD_ATTACH) begin
                if (!r_never_used[stlr_pkg::IDX_W]) begin
                    n_cur        = r_never_used;
                    n_never_used = r_never_used + 1'b1;
                    n_status     = stlr_pkg::ST_ADDED;
                    n_slot       = r_never_used[stlr_pkg::IDX_W-1:0];
                    n_state      = stlr_pkg::S_LINK1;
                end else if (!r_ret_head[stlr_pkg::IDX_W]) begin
                    n_cur     = r_ret_head;
                    n_recycle = 1'b1;
                    n_state   = stlr_pkg::S_READ;
                end else begin
                    n_status = stlr_pkg::ST_FULL;
                    n_state  = stlr_pkg::S_FINISH;
                end
            end else begin
                n_state = stlr_pkg::S_FINISH;
            end
        end
    end

    assign busy                 = (r_state != stlr_pkg::S_IDLE);
    assign o_result_valid       = (r_state == stlr_pkg::S_FINISH);
    assign o_result.status      = r_status;
    assign o_result.slot        = r_slot;
    assign o_result.found_live  = r_found;
    assign o_result.moved_count = r_moved;

endmodule

>>> hw/rtl/stlr_link_mem.sv
// Next and previous link arrays of the slot table, with registered reads.
// Depends on stlr_pkg. Entries never written since reset read as no slot.
module stlr_link_mem (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  stlr_pkg::t_link_wr        i_wr,
    input  logic [stlr_pkg::IDX_W-1:0] i_rd_addr,
    output stlr_pkg::t_link_rd        o_rd
);

    logic [stlr_pkg::LINK_W-1:0] mem_next [stlr_pkg::ENTRIES];
    logic [stlr_pkg::LINK_W-1:0] mem_prev [stlr_pkg::ENTRIES];
    logic [stlr_pkg::ENTRIES-1:0] r_next_vld;
    logic [stlr_pkg::ENTRIES-1:0] r_prev_vld;
    logic [stlr_pkg::LINK_W-1:0] r_rd_next;
    logic [stlr_pkg::LINK_W-1:0] r_rd_prev;
    logic                        r_rd_next_vld;
    logic                        r_rd_prev_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_vld <= '0;
            r_prev_vld <= '0;
        end else begin
            if (i_wr.we_next) begin
                r_next_vld[i_wr.wa_next] <= 1'b1;
            end
            if (i_wr.we_prev) begin
                r_prev_vld[i_wr.wa_prev] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.we_next) begin
            mem_next[i_wr.wa_next] <= i_wr.wd_next;
        end
        if (i_wr.we_prev) begin
            mem_prev[i_wr.wa_prev] <= i_wr.wd_prev;
        end
        r_rd_next     <= mem_next[i_rd_addr];
        r_rd_prev     <= mem_prev[i_rd_addr];
        r_rd_next_vld <= r_next_vld[i_rd_addr];
        r_rd_prev_vld <= r_prev_vld[i_rd_addr];
    end

    assign o_rd.next = r_rd_next_vld ? r_rd_next : stlr_pkg::NONE_LINK;
    assign o_rd.prev = r_rd_prev_vld ? r_rd_prev : stlr_pkg::NONE_LINK;

endmodule
